// ===== hdl/lpcr_pkg.sv =====
// Shared types and constants for the length-prefixed chunk receiver.
`default_nettype none

package lpcr_pkg;

    // Data bytes between two sync characters, and the width of the chunk counter.
    localparam int CHUNK_BYTES = 16;
    localparam int CHUNK_W     = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_WORD_MODE = CFG_INDEX_W'(1);

    // Register reset values and the sync character.
    localparam logic [15:0] CAPACITY_RESET  = 16'd4096;
    localparam logic        WORD_MODE_RESET = 1'b1;
    localparam logic [7:0]  SYNC_BYTE       = 8'h41;

    // Most results that one received byte can cause.
    localparam int MAX_RESULTS = 3;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_TX    = 2'd0,
        KIND_STORE = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    // Receiver phases.
    typedef enum logic [1:0] {
        PH_HDR_HI  = 2'd0,
        PH_HDR_LO  = 2'd1,
        PH_RX_BYTE = 2'd2,
        PH_RX_WORD = 2'd3
    } phase_t;

    // One result word.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic [15:0] store_index;
        logic [15:0] store_value;
        logic [15:0] element_count;
        logic        accepted;
        logic        last;
    } result_t;

    // All results caused by one received byte, in order, with their count.
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [1:0]                count;
    } batch_t;

endpackage

`default_nettype wire

// ===== hdl/length_prefixed_chunk_receiver.sv =====
// Top level of the length-prefixed chunk receiver: input register and buffer wiring.
//
// Usage: received link bytes enter on rx_byte with in_valid/in_ready. Each frame is a
// big-endian 16-bit byte count followed by its data bytes. Every byte may cause up to
// three result words on the output channel (out_valid/out_ready): transmit bytes for
// the header echo, NACK zeros and the sync 'A', stores of data elements, and a done
// word at frame end. The last field marks the final word caused by one input byte.
// Registers capacity (index 0) and word_mode (index 1) are written through the
// cfg_valid/cfg_ready channel, which is always ready; write only while idle.
// A byte is accepted into the input register, and its results are loaded from there
// into the result buffer register, from which the first result is presented.
// The block takes one byte per cycle while each byte gives at most one result and
// out_ready is high; otherwise the single output port draining the per-byte result
// buffer sets the rate, and a byte with several results holds back the next one.
// Reset clears the frame state, so the next byte is taken as a header high byte, and
// restores capacity 4096 and word mode. When the receiver stalls, the current word
// holds, one further byte waits in the input register and in_ready then drops.
`default_nettype none

module length_prefixed_chunk_receiver (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [lpcr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire [lpcr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire [7:0]                       rx_byte,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [1:0]                      kind,
    output logic [7:0]                      tx_byte,
    output logic [15:0]                     store_index,
    output logic [15:0]                     store_value,
    output logic [15:0]                     element_count,
    output logic                            accepted,
    output logic                            last
);
    import lpcr_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       buf_free;
    logic       step;
    batch_t     batch;
    result_t    cur;

    // The input word moves on when the result buffer can take its results.
    assign cfg_ready = 1'b1;
    assign step      = in_valid_reg && buf_free;
    assign in_ready  = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Frame sequencing.
    lpcr_frame_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .byte_in   (in_byte_reg),
        .batch     (batch)
    );

    // Result buffering and output.
    lpcr_result_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .batch_in  (batch),
        .free      (buf_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cur       (cur)
    );

    assign kind          = cur.kind;
    assign tx_byte       = cur.tx_byte;
    assign store_index   = cur.store_index;
    assign store_value   = cur.store_value;
    assign element_count = cur.element_count;
    assign accepted      = cur.accepted;
    assign last          = cur.last;

endmodule

`default_nettype wire

// ===== hdl/lpcr_frame_ctrl.sv =====
// Frame sequencer: configuration registers, frame state and result generation per byte.
`default_nettype none

module lpcr_frame_ctrl (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_valid,
    input  wire [lpcr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire [lpcr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire                           step,
    input  wire [7:0]                     byte_in,
    output lpcr_pkg::batch_t              batch
);
    import lpcr_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [7:0]         header_high_reg, header_high_next;
    logic [15:0]        expected_reg, expected_next;
    logic [15:0]        received_reg, received_next;
    logic [7:0]         held_reg, held_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    logic [15:0]        capacity_reg;
    logic               word_mode_reg;

    logic [15:0]        nbytes;
    logic [15:0]        hdr_elems;
    logic               hdr_fits;
    logic               words;
    logic [16:0]        pos_inc;
    logic               final_byte;
    logic [CHUNK_W:0]   chunk_inc;
    logic               chunk_full;

    // Element count of a byte count: halved and rounded up in word mode.
    function automatic logic [15:0] elements_of(input logic [15:0] n, input logic w);
        return w ? ({1'b0, n[15:1]} + {15'b0, n[0]}) : n;
    endfunction

    function automatic result_t tx_res(input logic [7:0] b);
        result_t r;
        r = '0;
        r.kind    = KIND_TX;
        r.tx_byte = b;
        return r;
    endfunction

    function automatic result_t store_res(input logic [15:0] idx, input logic [15:0] val);
        result_t r;
        r = '0;
        r.kind        = KIND_STORE;
        r.store_index = idx;
        r.store_value = val;
        return r;
    endfunction

    function automatic result_t done_res(input logic [15:0] cnt, input logic acc);
        result_t r;
        r = '0;
        r.kind          = KIND_DONE;
        r.element_count = cnt;
        r.accepted      = acc;
        return r;
    endfunction

    // Header decode and data position tests.
    assign nbytes     = {header_high_reg, byte_in};
    assign hdr_elems  = elements_of(nbytes, word_mode_reg);
    assign hdr_fits   = (hdr_elems <= capacity_reg);
    assign words      = (phase_reg == PH_RX_WORD);
    assign pos_inc    = {1'b0, received_reg} + 17'd1;
    assign final_byte = (pos_inc >= {1'b0, expected_reg});
    assign chunk_inc  = {1'b0, chunk_reg} + {{CHUNK_W{1'b0}}, 1'b1};
    assign chunk_full = (chunk_inc >= (CHUNK_W + 1)'(CHUNK_BYTES));

    // Configuration registers; writes to unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAPACITY_RESET;
            word_mode_reg <= WORD_MODE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_CAPACITY)
            begin
                capacity_reg <= cfg_data[15:0];
            end
            else if (cfg_index == REG_WORD_MODE)
            begin
                word_mode_reg <= cfg_data[0];
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR_HI;
            header_high_reg <= 8'd0;
            expected_reg    <= 16'd0;
            received_reg    <= 16'd0;
            held_reg        <= 8'd0;
            chunk_reg       <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            header_high_reg <= header_high_next;
            expected_reg    <= expected_next;
            received_reg    <= received_next;
            held_reg        <= held_next;
            chunk_reg       <= chunk_next;
        end
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            case (phase_reg)
                PH_HDR_HI:
                begin
                    phase_next = PH_HDR_LO;
                end
                PH_HDR_LO:
                begin
                    if (hdr_fits && (nbytes != 16'd0))
                    begin
                        phase_next = word_mode_reg ? PH_RX_WORD : PH_RX_BYTE;
                    end
                    else
                    begin
                        phase_next = PH_HDR_HI;
                    end
                end
                PH_RX_BYTE, PH_RX_WORD:
                begin
                    if (final_byte)
                    begin
                        phase_next = PH_HDR_HI;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR_HI;
                end
            endcase
        end
    end

    // Results of the current byte and the datapath state updates.
    always_comb
    begin
        logic [1:0] n;
        n                = 2'd0;
        batch            = '0;
        header_high_next = header_high_reg;
        expected_next    = expected_reg;
        received_next    = received_reg;
        held_next        = held_reg;
        chunk_next       = chunk_reg;
        if (step)
        begin
            case (phase_reg)
                PH_HDR_HI:
                begin
                    header_high_next = byte_in;
                end
                PH_HDR_LO:
                begin
                    if (hdr_fits)
                    begin
                        // Echo the header as the acknowledge.
                        batch.res[0] = tx_res(header_high_reg);
                        batch.res[1] = tx_res(byte_in);
                        if (nbytes == 16'd0)
                        begin
                            batch.res[2] = done_res(16'd0, 1'b1);
                            n = 2'd3;
                        end
                        else
                        begin
                            n             = 2'd2;
                            expected_next = nbytes;
                            received_next = 16'd0;
                            chunk_next    = '0;
                            held_next     = 8'd0;
                        end
                    end
                    else
                    begin
                        // Refuse with two zero bytes and an empty done.
                        batch.res[0] = tx_res(8'd0);
                        batch.res[1] = tx_res(8'd0);
                        batch.res[2] = done_res(16'd0, 1'b0);
                        n = 2'd3;
                    end
                end
                PH_RX_BYTE, PH_RX_WORD:
                begin
                    // Store of the byte, of a completed pair, or of an unpaired final byte.
                    if (!words)
                    begin
                        batch.res[n] = store_res(received_reg, {8'd0, byte_in});
                        n = n + 2'd1;
                    end
                    else if (!received_reg[0])
                    begin
                        if (final_byte)
                        begin
                            batch.res[n] = store_res({1'b0, received_reg[15:1]},
                                                     {8'd0, byte_in});
                            n = n + 2'd1;
                        end
                        else
                        begin
                            held_next = byte_in;
                        end
                    end
                    else
                    begin
                        batch.res[n] = store_res({1'b0, received_reg[15:1]},
                                                 {held_reg, byte_in});
                        n = n + 2'd1;
                    end
                    received_next = pos_inc[15:0];
                    chunk_next    = chunk_inc[CHUNK_W-1:0];
                    // Sync character at the end of a chunk or of the frame.
                    if (chunk_full || final_byte)
                    begin
                        batch.res[n] = tx_res(SYNC_BYTE);
                        n = n + 2'd1;
                        chunk_next = '0;
                    end
                    if (final_byte)
                    begin
                        batch.res[n] = done_res(elements_of(expected_reg, words), 1'b1);
                        n = n + 2'd1;
                    end
                end
                default:
                begin
                    n = 2'd0;
                end
            endcase
            if (n != 2'd0)
            begin
                batch.res[n - 2'd1].last = 1'b1;
            end
        end
        batch.count = n;
    end

endmodule

`default_nettype wire

// ===== hdl/lpcr_result_buf.sv =====
// Result buffer: holds one byte's results and hands them out one word at a time.
`default_nettype none

module lpcr_result_buf (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               load,
    input  lpcr_pkg::batch_t  batch_in,
    output logic              free,
    output logic              out_valid,
    input  wire               out_ready,
    output lpcr_pkg::result_t cur
);
    import lpcr_pkg::*;

    batch_t     batch_reg;
    logic [1:0] rem_reg, rem_next;
    logic [1:0] pos_reg, pos_next;
    logic       pop;

    // Output word and handshake; the buffer frees up as its last word leaves.
    assign cur       = batch_reg.res[pos_reg];
    assign out_valid = (rem_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign free      = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && pop);

    // Read position and remaining count.
    always_comb
    begin
        rem_next = rem_reg;
        pos_next = pos_reg;
        if (load)
        begin
            rem_next = batch_in.count;
            pos_next = 2'd0;
        end
        else if (pop)
        begin
            rem_next = rem_reg - 2'd1;
            pos_next = pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
            pos_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
            pos_reg <= pos_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            batch_reg <= batch_in;
        end
    end

    // The read position never runs past the batch.
    a_pos_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, pos_reg} + {1'b0, rem_reg}) <= 3'd3)
        else $error("result buffer read position ran past the batch");

    // A loaded batch always marks its final word.
    a_batch_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (batch_in.count != 2'd0)) |-> batch_in.res[batch_in.count - 2'd1].last)
        else $error("loaded batch lacks a last mark");

    // The last mark shows exactly on the final word of a batch.
    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cur.last == (rem_reg == 2'd1)))
        else $error("last mark out of step with remaining count");

    // A waiting word is neither lost nor replaced by a new load.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("batch loaded over undelivered words");

endmodule

`default_nettype wire

// ===== verif/length_prefixed_chunk_receiver_checker.sv =====
// Checker for the length-prefixed chunk receiver: predicts every result word and compares.
`timescale 1ns / 100ps

module length_prefixed_chunk_receiver_checker (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_valid,
    input  wire                             cfg_ready,
    input  wire [lpcr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire [lpcr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire                             in_valid,
    input  wire                             in_ready,
    input  wire [7:0]                       rx_byte,
    input  wire                             out_valid,
    input  wire                             out_ready,
    input  wire [1:0]                       kind,
    input  wire [7:0]                       tx_byte,
    input  wire [15:0]                      store_index,
    input  wire [15:0]                      store_value,
    input  wire [15:0]                      element_count,
    input  wire                             accepted,
    input  wire                             last,
    output int                              mismatches,
    output int                              pending_results,
    output int                              results_checked
);
    import lpcr_pkg::*;

    // Shadow copy of the registers and of the frame state.
    logic [15:0] cap_reg;
    logic        word_reg;
    phase_t      rx_phase;
    logic [7:0]  hdr_hi;
    logic [15:0] expect_bytes;
    logic [15:0] got_bytes;
    logic [7:0]  high_byte;
    int          chunk_fill;

    // Result words still owed by the block, oldest first.
    result_t     owed_words[$];
    int          bad_count;
    int          seen_count;

    // Elements in a frame of the given byte count.
    function automatic logic [15:0] elem_count_of(input logic [15:0] nbytes, input logic words);
        if (words)
            return (nbytes >> 1) + {15'd0, nbytes[0]};
        return nbytes;
    endfunction

    function automatic result_t make_word(input kind_t k, input logic [7:0] tx,
                                          input logic [15:0] idx, input logic [15:0] val,
                                          input logic [15:0] cnt, input logic acc);
        result_t r;
        r.kind          = k;
        r.tx_byte       = tx;
        r.store_index   = idx;
        r.store_value   = val;
        r.element_count = cnt;
        r.accepted      = acc;
        r.last          = 1'b0;
        return r;
    endfunction

    // Work out the result words caused by one received byte and queue them.
    function void predict_byte(input logic [7:0] b);
        result_t     res [MAX_RESULTS];
        int          n;
        int          i;
        logic [15:0] nbytes;
        logic [15:0] pos;
        logic        words;
        logic        is_final;
        n = 0;
        case (rx_phase)
            PH_HDR_HI:
            begin
                hdr_hi   = b;
                rx_phase = PH_HDR_LO;
            end
            PH_HDR_LO:
            begin
                nbytes = {hdr_hi, b};
                if (elem_count_of(nbytes, word_reg) <= cap_reg)
                begin
                    // Acknowledge by echoing the header.
                    res[0] = make_word(KIND_TX, hdr_hi, '0, '0, '0, 1'b0);
                    res[1] = make_word(KIND_TX, b, '0, '0, '0, 1'b0);
                    n = 2;
                    if (nbytes == 16'd0)
                    begin
                        res[2] = make_word(KIND_DONE, '0, '0, '0, '0, 1'b1);
                        n = 3;
                        rx_phase = PH_HDR_HI;
                    end
                    else
                    begin
                        expect_bytes = nbytes;
                        got_bytes    = '0;
                        chunk_fill   = 0;
                        high_byte    = '0;
                        rx_phase     = word_reg ? PH_RX_WORD : PH_RX_BYTE;
                    end
                end
                else
                begin
                    // Refused: two zero bytes and an empty done word.
                    res[0] = make_word(KIND_TX, '0, '0, '0, '0, 1'b0);
                    res[1] = make_word(KIND_TX, '0, '0, '0, '0, 1'b0);
                    res[2] = make_word(KIND_DONE, '0, '0, '0, '0, 1'b0);
                    n = 3;
                    rx_phase = PH_HDR_HI;
                end
            end
            default:
            begin
                words    = (rx_phase == PH_RX_WORD);
                pos      = got_bytes;
                is_final = ({1'b0, pos} + 17'd1 >= {1'b0, expect_bytes});
                if (!words)
                begin
                    res[n] = make_word(KIND_STORE, '0, pos, {8'd0, b}, '0, 1'b0);
                    n++;
                end
                else if (!pos[0])
                begin
                    // An unpaired final byte is stored on its own.
                    if (is_final)
                    begin
                        res[n] = make_word(KIND_STORE, '0, pos >> 1, {8'd0, b}, '0, 1'b0);
                        n++;
                    end
                    else
                        high_byte = b;
                end
                else
                begin
                    res[n] = make_word(KIND_STORE, '0, pos >> 1, {high_byte, b}, '0, 1'b0);
                    n++;
                end
                got_bytes  = pos + 16'd1;
                chunk_fill = chunk_fill + 1;
                if (chunk_fill >= CHUNK_BYTES || is_final)
                begin
                    res[n] = make_word(KIND_TX, SYNC_BYTE, '0, '0, '0, 1'b0);
                    n++;
                    chunk_fill = 0;
                end
                if (is_final)
                begin
                    res[n] = make_word(KIND_DONE, '0, '0, '0,
                                       elem_count_of(expect_bytes, words), 1'b1);
                    n++;
                    rx_phase = PH_HDR_HI;
                end
            end
        endcase
        if (n > 0)
            res[n-1].last = 1'b1;
        for (i = 0; i < n; i++)
            owed_words.push_back(res[i]);
    endfunction

    // Compare one delivered word with the oldest owed word.
    function void compare_word();
        result_t want;
        if (owed_words.size() == 0)
        begin
            if (bad_count < 10)
            begin
                $display("[%0t] unexpected word", $realtime);
                $display("got  kind %0d tx %02h idx %0d val %04h cnt %0d acc %0b last %0b",
                         kind, tx_byte, store_index, store_value, element_count,
                         accepted, last);
            end
            bad_count++;
            return;
        end
        want = owed_words.pop_front();
        if (kind !== want.kind || tx_byte !== want.tx_byte || store_index !== want.store_index
            || store_value !== want.store_value || element_count !== want.element_count
            || accepted !== want.accepted || last !== want.last)
        begin
            if (bad_count < 10)
            begin
                $display("[%0t] word %0d differs", $realtime, seen_count);
                $display("want kind %0d tx %02h idx %0d val %04h cnt %0d acc %0b last %0b",
                         want.kind, want.tx_byte, want.store_index, want.store_value,
                         want.element_count, want.accepted, want.last);
                $display("got  kind %0d tx %02h idx %0d val %04h cnt %0d acc %0b last %0b",
                         kind, tx_byte, store_index, store_value, element_count,
                         accepted, last);
            end
            bad_count++;
        end
    endfunction

    // Observe all three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      = CAPACITY_RESET;
            word_reg     = WORD_MODE_RESET;
            rx_phase     = PH_HDR_HI;
            hdr_hi       = '0;
            expect_bytes = '0;
            got_bytes    = '0;
            high_byte    = '0;
            chunk_fill   = 0;
            bad_count    = 0;
            seen_count   = 0;
            owed_words.delete();
            mismatches      <= 0;
            pending_results <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                compare_word();
                seen_count++;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_CAPACITY)
                    cap_reg = cfg_data[15:0];
                else if (cfg_index == REG_WORD_MODE)
                    word_reg = cfg_data[0];
            end
            if (in_valid && in_ready)
                predict_byte(rx_byte);
            mismatches      <= bad_count;
            pending_results <= owed_words.size();
            results_checked <= seen_count;
        end
    end

endmodule

// ===== verif/length_prefixed_chunk_receiver_test.sv =====
// Testbench top for the length-prefixed chunk receiver: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module length_prefixed_chunk_receiver_test;
    import lpcr_pkg::*;

    // Index that no register answers to.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = CFG_INDEX_W'(15);

    localparam int RESET_CYCLES  = 11;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BYTES  = 430;
    localparam int CALM_BYTES    = 90;
    localparam int PRESSURE_LEN  = 100;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [7:0]             rx_byte   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b1;
    logic [1:0]             kind;
    logic [7:0]             tx_byte;
    logic [15:0]            store_index;
    logic [15:0]            store_value;
    logic [15:0]            element_count;
    logic                   accepted;
    logic                   last;

    int                     mismatches;
    int                     pending_results;
    int                     results_checked;

    // Shared between the sender and the receiver process.
    bit                     idle_on    = 1'b1;
    bit                     hold_req   = 1'b0;
    bit                     hold_taken = 1'b0;

    // Shadow of the registers, used only to shape frames.
    logic [15:0]            cap_now  = CAPACITY_RESET;
    logic                   mode_now = WORD_MODE_RESET;
    int                     bytes_sent;
    int                     settings_used;
    int                     quiet_cycles;

    length_prefixed_chunk_receiver u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .tx_byte       (tx_byte),
        .store_index   (store_index),
        .store_value   (store_value),
        .element_count (element_count),
        .accepted      (accepted),
        .last          (last)
    );

    length_prefixed_chunk_receiver_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .tx_byte         (tx_byte),
        .store_index     (store_index),
        .store_value     (store_value),
        .element_count   (element_count),
        .accepted        (accepted),
        .last            (last),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    always #1 clk = ~clk;

    // Offer one received byte, with an occasional gap before it.
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // Write one register; the caller lowers cfg_valid after the last write.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_CAPACITY)
            cap_now = val;
        else if (idx == REG_WORD_MODE)
            mode_now = val[0];
    endtask

    task automatic apply_setting(input logic [15:0] cap, input logic mode);
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_WORD_MODE, {15'($urandom), mode});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Wait until every owed word has come out and the block has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Send a header and, if the block will take the frame, its data bytes.
    task automatic send_frame(input int nbytes);
        logic [15:0] hdr;
        int          elems;
        hdr   = 16'(nbytes);
        elems = mode_now ? (nbytes + 1) / 2 : nbytes;
        send_byte(hdr[15:8]);
        send_byte(hdr[7:0]);
        if (elems <= int'(cap_now))
            repeat (nbytes) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Byte count for a random frame: mostly short ones, with empty frames,
    // refusals and exact fits mixed in.
    function automatic int pick_length();
        int r;
        int lo;
        int top_elems;
        r = $urandom_range(0, 99);
        top_elems = mode_now ? 32768 : 65535;
        if (r < 8)
            return 0;
        if (r < 22 && int'(cap_now) < top_elems)
        begin
            lo = mode_now ? 2 * int'(cap_now) + 1 : int'(cap_now) + 1;
            if (r < 15)
                return lo;
            return $urandom_range(lo, 65535);
        end
        if (r < 34 && cap_now >= 1 && cap_now <= 48)
            return mode_now ? 2 * int'(cap_now) - int'($urandom_range(0, 1)) : int'(cap_now);
        return $urandom_range(1, 40);
    endfunction

    // Receiver side: ready stretches, short stalls and one long hold.
    initial
    begin
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Watchdog on cycles in which no word moves on any channel.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[%0t] no word moved for %0d cycles, %0d results still owed",
                         $realtime, quiet_cycles, pending_results);
                $display("FAIL length_prefixed_chunk_receiver");
                $finish;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int random_start;
        int frames;
        int phase_no;
        int sel;
        logic [15:0] cap;
        bytes_sent    = 0;
        settings_used = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: empty frame, a refused maximum header, odd final byte.
        send_byte(8'h00); send_byte(8'h00);
        send_byte(8'hFF); send_byte(8'hFF);
        send_byte(8'h00); send_byte(8'h03);
        send_byte(8'hFF); send_byte(8'h00); send_byte(8'h80);

        // A word-mode frame interrupted by register writes keeps its mode.
        send_byte(8'h00); send_byte(8'h05);
        send_byte(8'h12); send_byte(8'h34);
        settle();
        write_reg(REG_WORD_MODE, 16'hFFFE);
        write_reg(REG_CAPACITY, 16'h0000);
        write_reg(REG_SPARE, 16'hFFFF);
        cfg_valid <= 1'b0;
        settings_used++;
        send_byte(8'h56); send_byte(8'h78); send_byte(8'h9A);

        // Zero capacity in byte mode: an empty frame fits, one byte does not.
        send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h01);
        settle();

        // A frame that exactly fills the capacity.
        write_reg(REG_CAPACITY, 16'd2);
        cfg_valid <= 1'b0;
        send_byte(8'h00); send_byte(8'h02);
        send_byte(8'hAA); send_byte(8'h55);
        settle();

        // Random settings with a handful of frames each, and one with a single long frame.
        random_start = bytes_sent;
        phase_no     = 0;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            idle_on = (bytes_sent - random_start < RANDOM_BYTES - CALM_BYTES);
            if (phase_no == 1)
            begin
                // Long byte-mode frame while the receiver holds off.
                apply_setting(16'hFFFF, 1'b0);
                hold_req = 1'b1;
                send_frame(PRESSURE_LEN);
            end
            else
            begin
                sel = $urandom_range(0, 5);
                case (sel)
                    0:       cap = 16'h0000;
                    1:       cap = 16'hFFFF;
                    2, 3:    cap = 16'($urandom_range(0, 48));
                    4:       cap = 16'($urandom);
                    default: cap = 16'($urandom_range(1, 20));
                endcase
                apply_setting(cap, 1'($urandom_range(0, 1)));
                frames = $urandom_range(3, 6);
                repeat (frames) send_frame(pick_length());
            end
            settle();
            phase_no++;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d bytes, %0d register settings and a %0d-cycle output hold.",
                 bytes_sent, settings_used, HOLD_CYCLES);
        $display("%0d result words were checked; %0d differed and %0d were never delivered.",
                 results_checked, mismatches, pending_results);
        if (mismatches == 0 && pending_results == 0)
            $display("PASS length_prefixed_chunk_receiver");
        else
            $display("FAIL length_prefixed_chunk_receiver");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lpcr_pkg.sv
hdl/lpcr_frame_ctrl.sv
hdl/lpcr_result_buf.sv
hdl/length_prefixed_chunk_receiver.sv
verif/length_prefixed_chunk_receiver_checker.sv
verif/length_prefixed_chunk_receiver_test.sv
